@@ design/altilt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// altilt_pkg: shared constants for the smoothed tilt angle block
// Holds the default configuration values, the fixed field widths and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package altilt_pkg;
    localparam int          FRAC_BITS_DEF    = 16;
    localparam int          CORDIC_STEPS_DEF = 16;
    localparam int          GAIN_W           = 16;
    localparam int          RAW_W            = 16;
    localparam int          DEG_W            = 8;
    localparam int          ONE_G            = 16000;
    localparam logic [15:0] GAIN_RESET       = 16'd3277;
    localparam int          TABLE_LEN        = 24;
    localparam int          ANG_W            = 25;

    function automatic logic [ANG_W-1:0] atan_deg(input logic [4:0] i);
        logic [ANG_W-1:0] v;
        unique case (i)
            5'd0:    v = 25'd2949120;
            5'd1:    v = 25'd1740967;
            5'd2:    v = 25'd919879;
            5'd3:    v = 25'd466945;
            5'd4:    v = 25'd234379;
            5'd5:    v = 25'd117304;
            5'd6:    v = 25'd58666;
            5'd7:    v = 25'd29335;
            5'd8:    v = 25'd14668;
            5'd9:    v = 25'd7334;
            5'd10:   v = 25'd3667;
            5'd11:   v = 25'd1833;
            5'd12:   v = 25'd917;
            5'd13:   v = 25'd458;
            5'd14:   v = 25'd229;
            5'd15:   v = 25'd115;
            5'd16:   v = 25'd57;
            5'd17:   v = 25'd29;
            5'd18:   v = 25'd14;
            5'd19:   v = 25'd7;
            5'd20:   v = 25'd4;
            5'd21:   v = 25'd2;
            5'd22:   v = 25'd1;
            default: v = 25'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ design/accel_lowpass_tilt_angle.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_lowpass_tilt_angle: smoothed accelerometer tilt angle
// Usage:
//   Input channel i_valid/o_ready carries one word: raw_x, raw_y, raw_z.
//   Output channel o_valid/i_ready carries one word: tilt_degrees.
//   i_cfg_we writes filter_gain (Q0.16); user writes only when idle, unchecked.
// Timing:
//   One word in flight at a time. Per word: filter (16 gain bits, one per
//   cycle, plus settling), range check with a halving shift of all axes until
//   they fit in 30 bits (at most 2 halvings at the default fraction bits),
//   square root (one result bit per cycle), CORDIC iterations (CORDIC_STEPS,
//   at most the table length) and a finish step. An all-zero vector skips to
//   the result after the range check. The next word is taken only once the
//   block is back in idle, which it enters as it raises the result.
// Reset:
//   filter state goes to (0, 0, 1 g), gain to 3277, output empty.
// Stall:
//   the result waits in the output register; a new word is still taken,
//   and its finish step holds until the receiver has taken the old result.
// ----------------------------------------------------------------------------
module accel_lowpass_tilt_angle
    import altilt_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [RAW_W-1:0] i_raw_x,
    input  wire logic signed [RAW_W-1:0] i_raw_y,
    input  wire logic signed [RAW_W-1:0] i_raw_z,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [DEG_W-1:0]             o_tilt_degrees,
    input  wire logic                    i_cfg_we,
    input  wire logic [GAIN_W-1:0]       i_cfg_data
);
    localparam int SW     = 17 + FRAC_BITS;
    localparam int STEPS  = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int MW     = 30;
    localparam int QW     = 62;
    localparam int CW     = 34;
    localparam int TW     = 27;
    localparam logic [SW-1:0] ONE_G_Q = SW'(ONE_G) << FRAC_BITS;
    localparam logic [TW-1:0] FULL    = TW'(180 * 65536);

    localparam logic [2:0] S_IDLE = 3'd0, S_FILT = 3'd1, S_NORM = 3'd2,
                           S_SQRT = 3'd3, S_CORD = 3'd4, S_FIN = 3'd5;

    logic [2:0]          r_st, n_st;
    logic [GAIN_W-1:0]   r_gain;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_ov, n_ov;
    logic [DEG_W-1:0]    r_deg, n_deg;
    logic [SW-1:0]       r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    logic                r_neg, n_neg;
    logic [QW-1:0]       r_n, n_n, r_res, n_res;
    logic signed [CW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [TW-1:0] r_th, n_th;
    logic [QW-1:0]       bitv, trial;
    logic signed [TW-1:0] tot;
    logic                start;
    logic signed [SW-1:0] fx, fy, fz;

    assign o_ready        = (r_st == S_IDLE);
    assign o_valid        = r_ov;
    assign o_tilt_degrees = r_deg;
    assign start          = i_valid && o_ready;

    altilt_filter #(.FRAC_BITS(FRAC_BITS), .RESET_VAL('0)) u_fx (
        .i_clk, .i_rst_n, .i_start(start), .i_raw(i_raw_x), .i_gain(r_gain), .o_state(fx));
    altilt_filter #(.FRAC_BITS(FRAC_BITS), .RESET_VAL('0)) u_fy (
        .i_clk, .i_rst_n, .i_start(start), .i_raw(i_raw_y), .i_gain(r_gain), .o_state(fy));
    altilt_filter #(.FRAC_BITS(FRAC_BITS), .RESET_VAL(ONE_G_Q)) u_fz (
        .i_clk, .i_rst_n, .i_start(start), .i_raw(i_raw_z), .i_gain(r_gain), .o_state(fz));

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ov = r_ov; n_deg = r_deg;
        n_ax = r_ax; n_ay = r_ay; n_az = r_az; n_neg = r_neg;
        n_n = r_n; n_res = r_res; n_cx = r_cx; n_cy = r_cy; n_th = r_th;
        bitv  = QW'(1) << {r_cnt, 1'b0};
        trial = r_res + bitv;
        tot   = r_neg ? (TW'(FULL) - r_th) : r_th;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (start) begin
                    n_st  = S_FILT;
                    n_cnt = '0;
                end
            end
            S_FILT: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(GAIN_W + 1)) begin
                    n_neg = fx[SW-1];
                    n_ax  = fx[SW-1] ? SW'(-fx) : fx;
                    n_ay  = fy[SW-1] ? SW'(-fy) : fy;
                    n_az  = fz[SW-1] ? SW'(-fz) : fz;
                    n_st  = S_NORM;
                end
            end
            S_NORM: begin
                if ((r_ax | r_ay | r_az) == '0) begin
                    if (!r_ov || i_ready) begin
                        n_deg = DEG_W'(90);
                        n_ov  = 1'b1;
                        n_st  = S_IDLE;
                    end
                end else if (((r_ax | r_ay | r_az) >> MW) != '0) begin
                    n_ax = r_ax >> 1; n_ay = r_ay >> 1; n_az = r_az >> 1;
                end else begin
                    n_n   = QW'(r_ay[MW-1:0]) * QW'(r_ay[MW-1:0])
                          + QW'(r_az[MW-1:0]) * QW'(r_az[MW-1:0]);
                    n_res = '0;
                    n_cnt = 5'd30;
                    n_st  = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_n >= trial) begin
                    n_n   = r_n - trial;
                    n_res = (r_res >> 1) + bitv;
                end else begin
                    n_res = r_res >> 1;
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_cx  = CW'(r_ax[MW-1:0]);
                    n_cy  = CW'(n_res);
                    n_th  = '0;
                    n_cnt = '0;
                    n_st  = S_CORD;
                end
            end
            S_CORD: begin
                if (r_cy > 0) begin
                    n_cx = r_cx + (r_cy >>> r_cnt);
                    n_cy = r_cy - (r_cx >>> r_cnt);
                    n_th = r_th + TW'(atan_deg(r_cnt));
                end else begin
                    n_cx = r_cx - (r_cy >>> r_cnt);
                    n_cy = r_cy + (r_cx >>> r_cnt);
                    n_th = r_th - TW'(atan_deg(r_cnt));
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(STEPS - 1)) n_st = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || i_ready) begin
                    if (tot < 0)                 n_deg = '0;
                    else if (tot > $signed(FULL)) n_deg = DEG_W'(180);
                    else                         n_deg = DEG_W'(tot >>> 16);
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_ov   <= 1'b0;
            r_gain <= GAIN_RESET;
            r_cnt  <= '0;
        end else begin
            r_st  <= n_st;
            r_ov  <= n_ov;
            r_cnt <= n_cnt;
            if (i_cfg_we) r_gain <= i_cfg_data;
        end
        r_deg <= n_deg; r_ax <= n_ax; r_ay <= n_ay; r_az <= n_az;
        r_neg <= n_neg; r_n <= n_n; r_res <= n_res;
        r_cx <= n_cx; r_cy <= n_cy; r_th <= n_th;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tilt_degrees <= DEG_W'(180))) else $error("angle out of range");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FIN) |=> o_valid) else $error("result lost");
    a_start_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_st == S_FILT)) else $error("sequencer did not start");
`endif
endmodule
`default_nettype wire

@@ design/altilt_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// altilt_filter: bit-serial one-pole low-pass for one axis
// Computes f + floor((x<<F - f) * gain / 2^16) with a shift-add multiplier
// that consumes one gain bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module altilt_filter
    import altilt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter logic [17+FRAC_BITS-1:0] RESET_VAL = '0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [RAW_W-1:0]  i_raw,
    input  wire logic [GAIN_W-1:0]        i_gain,
    output logic signed [17+FRAC_BITS-1:0] o_state
);
    localparam int SW = 17 + FRAC_BITS;
    localparam int DW = SW + 1;
    localparam int AW = DW + 1;

    logic signed [SW-1:0] r_f, n_f;
    logic signed [DW-1:0] r_d, n_d;
    logic signed [AW-1:0] r_acc, n_acc;
    logic [GAIN_W-1:0]    r_g, n_g;
    logic [4:0]           r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic signed [AW-1:0] sum;

    assign o_state = r_f;

    // acc holds partial product >> k, low bits dropped (floor)
    always_comb begin
        n_f = r_f; n_d = r_d; n_acc = r_acc; n_g = r_g;
        n_cnt = r_cnt; n_busy = r_busy;
        sum = r_acc + (r_g[0] ? AW'(r_d) : AW'(0));
        if (i_start) begin
            n_d    = {{(DW-RAW_W-FRAC_BITS){i_raw[RAW_W-1]}}, i_raw, {FRAC_BITS{1'b0}}}
                     - DW'(r_f);
            n_acc  = '0;
            n_g    = i_gain;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = sum >>> 1;
            n_g   = r_g >> 1;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(GAIN_W - 1)) begin
                n_busy = 1'b0;
                n_f    = r_f + SW'(sum >>> 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f    <= RESET_VAL;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_f    <= n_f;
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_d   <= n_d;
        r_acc <= n_acc;
        r_g   <= n_g;
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("filter restarted while busy");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 5'(GAIN_W - 1)) |=> !r_busy) else $error("filter overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_start) |=> $stable(r_f)) else $error("state moved while idle");
`endif
endmodule
`default_nettype wire
